/* src/wpf_pkg.sv */
package wpf_pkg;

   // Low SAMPLE_BITS bits of the sample field carry the two's complement ADC value
   localparam int SAMPLE_BITS = 16;
   // Sample index counter width; index outputs carry its low DATA_BITS bits
   localparam int INDEX_BITS = 16;
   localparam int DATA_BITS = 16;
   // Offset-corrected sample: 16 bit minus 16 bit signed
   localparam int VALUE_BITS = DATA_BITS + 1;
   // Samples at the head of a waveform that only fill the history
   localparam int WARMUP = 3;
   localparam int HIST_DEPTH = 3;
   localparam int CSR_INDEX_BITS = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_VERTICAL_OFFSET = 1'b0,
      REG_NOISE_THRESHOLD = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] sample;
      logic                        last_sample;
   } req_word_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] peak_start;
      logic [DATA_BITS-1:0] peak_stop;
      logic [DATA_BITS-1:0] max_position;
      logic [DATA_BITS-1:0] max_height;
      logic                 negative_polarity;
   } rsp_word_type;

   // Corrected sample handed from the input stage to the detector
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [DATA_BITS-1:0]         mag;
      logic                         last;
   } corr_type;

   // Handshake between input stage and detector
   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

/* src/wpf_correct.sv */
module wpf_correct (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wpf_pkg::req_word_type         req_word,
   input  logic signed [wpf_pkg::DATA_BITS-1:0] vertical_offset,
   input  logic                          advance,
   output logic                          corr_valid,
   output wpf_pkg::corr_type             corr_word
);

   logic                                      valid_ff;
   logic                                      valid_in;
   wpf_pkg::corr_type                         word_ff;
   wpf_pkg::corr_type                         word_in;
   logic signed [wpf_pkg::VALUE_BITS-1:0]     raw_ext;
   logic signed [wpf_pkg::VALUE_BITS-1:0]     ofs_ext;
   logic signed [wpf_pkg::VALUE_BITS-1:0]     diff;
   logic                                      take;

   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      raw_ext = wpf_pkg::VALUE_BITS'($signed(req_word.sample[wpf_pkg::SAMPLE_BITS-1:0]));
      ofs_ext = wpf_pkg::VALUE_BITS'(vertical_offset);
      diff    = raw_ext - ofs_ext;
      word_in.value = diff;
      word_in.mag   = diff[wpf_pkg::VALUE_BITS-1] ?
                      wpf_pkg::DATA_BITS'(-diff) : wpf_pkg::DATA_BITS'(diff);
      word_in.last  = req_word.last_sample;
      valid_in = take || (valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload: load on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign corr_valid = valid_ff;
   assign corr_word  = word_ff;

endmodule

/* src/wpf_detect.sv */
module wpf_detect (
   input  logic                            clock,
   input  logic                            reset,
   input  wpf_pkg::stage_ctl_type          ctl_in,
   output logic                            advance,
   input  wpf_pkg::corr_type               corr_word,
   input  logic [wpf_pkg::DATA_BITS-1:0]   noise_threshold,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output wpf_pkg::rsp_word_type           rsp_word
);

   localparam int IB = wpf_pkg::INDEX_BITS;
   localparam int DB = wpf_pkg::DATA_BITS;
   localparam int HD = wpf_pkg::HIST_DEPTH;

   logic [DB-1:0]  hist_mag_ff [HD];
   logic           hist_neg_ff [HD];
   logic [IB-1:0]  idx_ff, idx_in;
   logic           rising_ff, rising_in;
   logic           in_run_ff, in_run_in;
   logic [IB-1:0]  start_ff, start_in;
   logic [DB-1:0]  best_h_ff, best_h_in;
   logic [IB-1:0]  best_pos_ff, best_pos_in;
   logic           best_neg_ff, best_neg_in;
   logic           out_valid_ff, out_valid_in;
   wpf_pkg::rsp_word_type out_word_ff, out_word_in;

   logic           fire;
   logic           warm;
   logic           cur_neg, cur_pos, prev_neg, prev_pos;
   logic           sign_change;
   logic           run_end;
   logic           emit;
   logic           chain;
   logic [IB-1:0]  stop_idx;

   assign fire    = ctl_in.valid && (!out_valid_ff || rsp_ready);
   assign advance = fire;

   always_comb begin
      warm      = idx_ff < IB'(wpf_pkg::WARMUP);
      cur_neg   = corr_word.value < 0;
      cur_pos   = corr_word.value > 0;
      prev_neg  = hist_neg_ff[0];
      prev_pos  = !hist_neg_ff[0] && (hist_mag_ff[0] != '0);
      sign_change = (cur_neg && prev_pos) || (cur_pos && prev_neg);
      run_end   = (corr_word.mag <= noise_threshold) || corr_word.last || sign_change;
      emit      = !warm && run_end && rising_ff;
      chain     = (hist_mag_ff[2] < hist_mag_ff[1]) && (hist_mag_ff[1] < hist_mag_ff[0]) &&
                  (hist_mag_ff[0] < corr_word.mag);
      stop_idx  = idx_ff - IB'(1);

      rising_in   = rising_ff;
      in_run_in   = in_run_ff;
      start_in    = start_ff;
      best_h_in   = best_h_ff;
      best_pos_in = best_pos_ff;
      best_neg_in = best_neg_ff;

      if (warm || run_end) begin
         // Drop any run in progress
         rising_in = 1'b0;
         in_run_in = 1'b0;
      end else begin
         if (!in_run_ff) begin
            in_run_in   = 1'b1;
            start_in    = idx_ff;
            best_h_in   = corr_word.mag;
            best_pos_in = idx_ff;
            best_neg_in = cur_neg;
         end else if (corr_word.mag > best_h_ff) begin
            best_h_in   = corr_word.mag;
            best_pos_in = idx_ff;
            best_neg_in = cur_neg;
         end
         if (!rising_ff && chain) begin
            rising_in = 1'b1;
         end
      end

      if (corr_word.last) begin
         idx_in    = '0;
         in_run_in = 1'b0;
         rising_in = 1'b0;
      end else begin
         idx_in = idx_ff + IB'(1);
      end

      out_word_in.peak_start        = DB'(start_ff);
      out_word_in.peak_stop         = DB'(stop_idx);
      out_word_in.max_position      = DB'(best_pos_ff);
      out_word_in.max_height        = best_h_ff;
      out_word_in.negative_polarity = best_neg_ff;

      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rising_ff    <= 1'b0;
         in_run_ff    <= 1'b0;
         start_ff     <= '0;
         best_h_ff    <= '0;
         best_pos_ff  <= '0;
         best_neg_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k < HD; k++) begin
            hist_mag_ff[k] <= '0;
            hist_neg_ff[k] <= 1'b0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            idx_ff      <= idx_in;
            rising_ff   <= rising_in;
            in_run_ff   <= in_run_in;
            start_ff    <= start_in;
            best_h_ff   <= best_h_in;
            best_pos_ff <= best_pos_in;
            best_neg_ff <= best_neg_in;
            // Shift the history, newest first
            for (int k = HD - 1; k > 0; k--) begin
               hist_mag_ff[k] <= hist_mag_ff[k-1];
               hist_neg_ff[k] <= hist_neg_ff[k-1];
            end
            hist_mag_ff[0] <= corr_word.mag;
            hist_neg_ff[0] <= cur_neg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_word_ff <= out_word_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   a_rising_in_run : assert property (@(posedge clock) disable iff (reset)
      rising_ff |-> in_run_ff)
      else $error("rising flag set outside a run");

   a_emit_shows : assert property (@(posedge clock) disable iff (reset)
      fire && emit |=> rsp_valid)
      else $error("peak emitted but no word presented");

   a_word_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(fire) && $past(emit))
      else $error("result word appeared without an emitting sample");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      fire && corr_word.last |=> idx_ff == '0 && !in_run_ff && !rising_ff)
      else $error("final sample did not restart the waveform");

endmodule

/* src/waveform_peak_finder.sv */
// Waveform peak finder. Takes one raw ADC sample per word, subtracts the
// vertical offset and reports each peak (a run of samples above the noise
// threshold, cut by a noise sample, a sign change or the final sample, that
// held four strictly rising magnitudes) as one result word giving the run's
// first and last index, the index of its first largest magnitude, that
// magnitude and its polarity. The first three samples of each waveform only
// fill the history. One sample is accepted every clock cycle as long as the
// result side is ready; a peak is presented once the sample that ends it has
// passed the offset stage and then the single-pass detector stage.
// Write the offset and threshold only while no samples are in flight.
module waveform_peak_finder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  wpf_pkg::req_word_type                  req_word,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output wpf_pkg::rsp_word_type                  rsp_word,
   input  logic                                   csr_write_en,
   input  logic [wpf_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [wpf_pkg::DATA_BITS-1:0]          csr_wdata
);

   logic signed [wpf_pkg::DATA_BITS-1:0] offset_ff;
   logic [wpf_pkg::DATA_BITS-1:0]        threshold_ff;
   logic                                 corr_valid;
   logic                                 advance;
   wpf_pkg::corr_type                    corr_word;
   wpf_pkg::stage_ctl_type               stage_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         threshold_ff <= '0;
      end else if (csr_write_en) begin
         case (wpf_pkg::csr_reg_type'(csr_index))
            wpf_pkg::REG_VERTICAL_OFFSET: begin
               offset_ff <= $signed(csr_wdata);
            end
            wpf_pkg::REG_NOISE_THRESHOLD: begin
               threshold_ff <= csr_wdata;
            end
            default: begin
               offset_ff <= offset_ff;
            end
         endcase
      end
   end

   assign stage_ctl.valid   = corr_valid;
   assign stage_ctl.advance = advance;

   wpf_correct u_correct (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_word        (req_word),
      .vertical_offset (offset_ff),
      .advance         (stage_ctl.advance),
      .corr_valid      (corr_valid),
      .corr_word       (corr_word)
   );

   wpf_detect u_detect (
      .clock           (clock),
      .reset           (reset),
      .ctl_in          (stage_ctl),
      .advance         (advance),
      .corr_word       (corr_word),
      .noise_threshold (threshold_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word)
   );

endmodule

/* verif/wpf_peak_checker.sv */
module wpf_peak_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  wpf_pkg::req_word_type               req_word,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  wpf_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_write_en,
   input  logic [wpf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [wpf_pkg::DATA_BITS-1:0]       csr_wdata,
   output int                                  fail_count,
   output int                                  peaks_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import wpf_pkg::*;

   logic signed [DATA_BITS-1:0]  offset_q;
   logic [DATA_BITS-1:0]         threshold_q;
   logic signed [VALUE_BITS-1:0] history [HIST_DEPTH];
   logic [INDEX_BITS-1:0]        index_q;
   logic                         rising_q;
   logic                         in_run_q;
   logic [INDEX_BITS-1:0]        run_start_q;
   logic [INDEX_BITS-1:0]        best_pos_q;
   logic [DATA_BITS-1:0]         best_height_q;
   logic                         best_neg_q;
   rsp_word_type                 expected_peaks [$];
   int                           errors = 0;

   function automatic int magnitude(input int x);
      return (x < 0) ? -x : x;
   endfunction

   // Advance the detector by one sample word; returns 1 when a peak closes.
   function automatic bit detect_peak(input req_word_type w, output rsp_word_type peak);
      int value;
      int prev;
      int level;
      bit crossing;
      bit found;
      value = int'(w.sample) - int'(offset_q);
      level = magnitude(value);
      found = 1'b0;
      peak = '0;
      if (index_q < WARMUP) begin
         in_run_q = 1'b0;
         rising_q = 1'b0;
      end else begin
         prev = int'(history[0]);
         // a corrected zero never counts as a sign change
         crossing = (value < 0 && prev > 0) || (value > 0 && prev < 0);
         if (level <= int'(threshold_q) || w.last_sample || crossing) begin
            if (rising_q) begin
               peak.peak_start        = DATA_BITS'(run_start_q);
               peak.peak_stop         = DATA_BITS'(index_q - 1'b1);
               peak.max_position      = DATA_BITS'(best_pos_q);
               peak.max_height        = best_height_q;
               peak.negative_polarity = best_neg_q;
               found = 1'b1;
            end
            rising_q = 1'b0;
            in_run_q = 1'b0;
         end else begin
            if (!in_run_q) begin
               in_run_q      = 1'b1;
               run_start_q   = index_q;
               best_height_q = DATA_BITS'(level);
               best_pos_q    = index_q;
               best_neg_q    = (value < 0);
            end else if (level > int'(best_height_q)) begin
               best_height_q = DATA_BITS'(level);
               best_pos_q    = index_q;
               best_neg_q    = (value < 0);
            end
            if (!rising_q &&
                magnitude(history[2]) < magnitude(history[1]) &&
                magnitude(history[1]) < magnitude(history[0]) &&
                magnitude(history[0]) < level)
               rising_q = 1'b1;
         end
      end
      history[2] = history[1];
      history[1] = history[0];
      history[0] = VALUE_BITS'(value);
      if (w.last_sample) begin
         index_q  = '0;
         in_run_q = 1'b0;
         rising_q = 1'b0;
      end else begin
         index_q = index_q + 1'b1;
      end
      return found;
   endfunction

   always @(posedge clock) begin
      rsp_word_type peak;
      rsp_word_type want;
      if (reset) begin
         offset_q      = '0;
         threshold_q   = '0;
         history[0]    = '0;
         history[1]    = '0;
         history[2]    = '0;
         index_q       = '0;
         rising_q      = 1'b0;
         in_run_q      = 1'b0;
         run_start_q   = '0;
         best_pos_q    = '0;
         best_height_q = '0;
         best_neg_q    = 1'b0;
         expected_peaks.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_reg_type'(csr_index))
               REG_VERTICAL_OFFSET: offset_q = csr_wdata;
               REG_NOISE_THRESHOLD: threshold_q = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (detect_peak(req_word, peak))
               expected_peaks.push_back(peak);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_peaks.size() == 0) begin
               $error("peak word with none expected: %p", rsp_word);
               errors++;
            end else begin
               want = expected_peaks.pop_front();
               if (rsp_word.peak_start !== want.peak_start) begin
                  $error("peak_start expected %0d actual %0d",
                         want.peak_start, rsp_word.peak_start);
                  errors++;
               end
               if (rsp_word.peak_stop !== want.peak_stop) begin
                  $error("peak_stop expected %0d actual %0d",
                         want.peak_stop, rsp_word.peak_stop);
                  errors++;
               end
               if (rsp_word.max_position !== want.max_position) begin
                  $error("max_position expected %0d actual %0d",
                         want.max_position, rsp_word.max_position);
                  errors++;
               end
               if (rsp_word.max_height !== want.max_height) begin
                  $error("max_height expected %0d actual %0d",
                         want.max_height, rsp_word.max_height);
                  errors++;
               end
               if (rsp_word.negative_polarity !== want.negative_polarity) begin
                  $error("negative_polarity expected %0d actual %0d",
                         want.negative_polarity, rsp_word.negative_polarity);
                  errors++;
               end
            end
         end
      end
      peaks_pending <= expected_peaks.size();
      fail_count    <= errors;
   end

endmodule

/* verif/tb_waveform_peak_finder.sv */
module tb_waveform_peak_finder;
   timeunit 1ns;
   timeprecision 1ps;

   import wpf_pkg::*;

   localparam int CLOCK_PERIOD   = 12;
   localparam int DRAIN_CYCLES   = 6;
   localparam int PHASE_WORDS    = 270;
   localparam int TIMEOUT_CYCLES = 1_500_000;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   req_word_type              req_word;
   logic                      rsp_valid;
   logic                      rsp_ready;
   rsp_word_type              rsp_word;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [DATA_BITS-1:0]      csr_wdata;
   int                        fail_count;
   int                        peaks_pending;

   int           cur_offset = 0;
   int           cur_threshold = 0;
   int           words_sent = 0;
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   req_word_type waveform_words [$];

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   waveform_peak_finder DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   wpf_peak_checker peak_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .peaks_pending (peaks_pending)
   );

   task automatic send_word(input logic signed [DATA_BITS-1:0] sample, input logic last);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word.sample      <= sample;
      req_word.last_sample <= last;
      req_valid            <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   // Drop valid and wait until every predicted peak has come out.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (peaks_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= which;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int offset, input int threshold);
      settle();
      write_reg(REG_VERTICAL_OFFSET, DATA_BITS'(offset));
      write_reg(REG_NOISE_THRESHOLD, DATA_BITS'(threshold));
      cur_offset    = offset;
      cur_threshold = threshold;
   endtask

   // Raw sample for a given corrected value, clamped to the ADC range.
   function automatic logic signed [DATA_BITS-1:0] level_at(input int corrected);
      int raw;
      raw = cur_offset + corrected;
      if (raw > 32767) raw = 32767;
      if (raw < -32768) raw = -32768;
      return DATA_BITS'(raw);
   endfunction

   task automatic add_level(input int corrected);
      req_word_type w;
      w.sample      = level_at(corrected);
      w.last_sample = 1'b0;
      waveform_words.push_back(w);
   endtask

   task automatic add_noise();
      int amp;
      amp = $urandom_range(0, cur_threshold);
      add_level($urandom_range(0, 1) ? -amp : amp);
   endtask

   // Baseline, then a few pulses that rise, may plateau and fall, and end in noise,
   // a zero or the next pulse, which may flip polarity; sometimes cut short or left without a last word.
   task automatic send_waveform();
      int pol;
      int amp;
      int top;
      int stride;
      waveform_words.delete();
      repeat ($urandom_range(3, 6)) add_noise();
      repeat ($urandom_range(1, 4)) begin
         pol    = $urandom_range(0, 1) ? -1 : 1;
         amp    = cur_threshold + $urandom_range(1, 40);
         stride = ($urandom_range(0, 3) == 0) ? 20000 : $urandom_range(1, 500);
         top    = amp;
         repeat ($urandom_range(2, 7)) begin
            if (amp > 65535) amp = 65535;
            add_level(pol * amp);
            top = amp;
            amp += $urandom_range(1, stride);
         end
         if ($urandom_range(0, 3) == 0) add_level(pol * top);
         repeat ($urandom_range(0, 4)) begin
            top -= $urandom_range(1, stride);
            if (top <= cur_threshold) top = cur_threshold + 1;
            add_level(pol * top);
         end
         case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 4)) add_noise();
            1: add_level(0);
            default: ;
         endcase
      end
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) void'(waveform_words.pop_back());
      waveform_words[$].last_sample = ($urandom_range(0, 7) != 0);
      req_calm = ($urandom_range(0, 4) == 0);
      foreach (waveform_words[k])
         send_word(waveform_words[k].sample, waveform_words[k].last_sample);
   endtask

   initial begin
      int directed [] = '{5, 32767, 0, 0, 0, 1, 2, 3, 4, 0,
                          -1, -100, -1000, -32768, 32767, 100, 200, 300, 400, 500};
      int phase_end;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_word     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= REG_VERTICAL_OFFSET;
      csr_wdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // final word during warm-up, a plain peak, a sign-change cut, a last-word cut
      foreach (directed[k])
         send_word(DATA_BITS'(directed[k]), (k == 1 || k == directed.size() - 1));

      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(0, 0);
            1: configure(-32768, 0);
            2: configure(32767, 65535);
            3: configure(-32768, 32767);
            4: configure(32767, 1);
            default: configure($urandom_range(0, 65535) - 32768, $urandom_range(0, 3000));
         endcase
         phase_end = words_sent + ((phase == 2) ? 60 : PHASE_WORDS);
         while (words_sent < phase_end) begin
            if ($urandom_range(0, 6) == 0) begin
               req_calm = 1'b0;
               repeat ($urandom_range(1, 8))
                  send_word(DATA_BITS'($urandom), ($urandom_range(0, 15) == 0));
            end else begin
               send_waveform();
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
         stall = rsp_calm ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule
